@@ rtl/adt_pkg.sv @@
`default_nettype none

package adt_pkg;

	localparam int MAX_ENTRIES_DEF = 256;
	localparam int ALIGN_UNITS_DEF = 2048;

	localparam int            CAP_W     = 9;
	localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

	localparam int NAME_W = 192;

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_REM = 2'd1;
	localparam logic [1:0] CMD_SET = 2'd2;
	localparam logic [1:0] CMD_GET = 2'd3;

	typedef struct packed {
		logic [NAME_W-1:0] name;
		logic [31:0]       offset;
		logic [15:0]       ssize;
		logic [15:0]       asize;
	} entry_t;

	// Zero every byte after the first zero byte of a 24-byte name.
	function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] w);
		logic [NAME_W-1:0] c;
		logic              ended;
		c     = '0;
		ended = 1'b0;
		for (int k = 0; k < NAME_W / 8; k++) begin
			if (!ended) begin
				c[8*k +: 8] = w[8*k +: 8];
			end
			if (w[8*k +: 8] == 8'h00) begin
				ended = 1'b1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ rtl/archive_directory_table_unit.sv @@
// Archive directory table: a packed list of named entries (name, offset,
// streaming size, stored size) in one on-chip memory.
// Input stream s_*: one word per command. s_tuser carries the command
// (add, remove by name, set size, get size); s_tdata the name, index and sizes.
// Output stream m_*: exactly one result word per command. m_tuser is the
// ok flag, m_tdata the assigned offset and the size read back.
// cfg_we/cfg_wdata write the capacity register (reset 256); write it only
// while no command is in flight.
// Steps per command from the accept cycle:
//   add: name search, read of last entry, remainder by reciprocal
//   multiply, round-up, write; on an empty table only the write, none if full.
//   remove: search, then compaction of later entries; set/get: read, check.
//   Remove on an empty table and set/get with an absent index skip to result.
// All memory traffic goes through one read and one write port.
// s_tready is high only while idle. A finished result waits in the output
// register while m_tready is low; the next command is then taken but its
// result is held back until the register frees up.
// Reset empties the table at once (entry count cleared, no memory sweep).
`default_nettype none

module archive_directory_table_unit
	import adt_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int ALIGN_UNITS = ALIGN_UNITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [CAP_W-1:0]   cfg_wdata,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	// [63:0] name_word_0, [127:64] name_word_1, [191:128] name_word_2,
	// [207:192] entry_index, [223:208] stream_size, [239:224] archive_size
	input  wire logic [239:0]       s_tdata,
	// [1:0] cmd
	input  wire logic [1:0]         s_tuser,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	// [31:0] assigned_offset, [47:32] size_out
	output logic [47:0]             m_tdata,
	// [0] ok
	output logic [0:0]              m_tuser
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int LW = (CW > CAP_W) ? CW : CAP_W;
	localparam int XW = (CW > 16) ? CW : 16;
	localparam int AL_W = $clog2(ALIGN_UNITS);
	localparam logic [48:0] RCP_DEN = 49'(ALIGN_UNITS);
	localparam logic [48:0] RCP_NUM = 49'(1) << (32 + AL_W);
	localparam logic [32:0] RCP_MUL = 33'((RCP_NUM + RCP_DEN - 49'd1) / RCP_DEN);
	localparam logic [31:0] ALIGN_32 = 32'(ALIGN_UNITS);

	typedef enum logic [3:0] {
		S_IDLE, S_SRD, S_SCMP, S_MRD, S_MWR, S_LRD, S_SUM, S_RCP, S_QSUB,
		S_RND, S_WRADD, S_IRD, S_ICHK, S_OUT
	} state_t;

	state_t            state_q;
	logic [CAP_W-1:0]  cap_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     ptr_q;
	logic [1:0]        cmd_q;
	logic [NAME_W-1:0] key_q;
	logic [15:0]       ssz_q;
	logic [15:0]       asz_q;
	logic [31:0]       sum_q;
	logic [31:0]       rem_q;
	logic [64:0]       prod_q;
	logic              res_ok_q;
	logic [31:0]       res_off_q;
	logic [15:0]       res_size_q;
	logic              m_tvalid_q;
	logic [31:0]       m_off_q;
	logic [15:0]       m_size_q;
	logic              m_ok_q;

	entry_t            mem [MAX_ENTRIES];
	entry_t            rd_q;
	logic              wr_en;
	logic [IW-1:0]     wr_addr;
	entry_t            wr_data;

	logic [CW-1:0]     ptr_inc;
	logic [CW-1:0]     ptr_dec;
	logic [CW-1:0]     cnt_dec;
	logic              full;
	logic              idx_ok;
	logic              s_fire;
	logic [31:0]       quot;

	assign ptr_inc  = ptr_q + CW'(1);
	assign ptr_dec  = ptr_q - CW'(1);
	assign cnt_dec  = count_q - CW'(1);
	assign full     = (LW'(count_q) >= LW'(cap_q)) || (count_q == CW'(MAX_ENTRIES));
	assign idx_ok   = XW'(s_tdata[207:192]) < XW'(count_q);
	assign s_tready = (state_q == S_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign quot     = 32'(prod_q >> (32 + AL_W));

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {m_size_q, m_off_q};
	assign m_tuser  = m_ok_q;

	// Simple dual-port memory: one write, one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[ptr_q[IW-1:0]];
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ptr_q[IW-1:0];
		wr_data = rd_q;
		case (state_q)
			S_MWR: begin
				wr_en   = 1'b1;
				wr_addr = ptr_dec[IW-1:0];
			end
			S_WRADD: begin
				wr_en   = 1'b1;
				wr_addr = count_q[IW-1:0];
				wr_data = '{name: key_q, offset: sum_q, ssize: ssz_q, asize: asz_q};
			end
			S_ICHK: begin
				wr_en         = (cmd_q == CMD_SET) && (rd_q.ssize != ssz_q);
				wr_data.ssize = ssz_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cap_q      <= CAP_RESET;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			// drop the word once taken, unless a new one is loaded now
			if (m_tvalid_q && m_tready && (state_q != S_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_fire) begin
						cmd_q      <= s_tuser;
						key_q      <= canon_name(s_tdata[191:0]);
						ssz_q      <= s_tdata[223:208];
						asz_q      <= s_tdata[239:224];
						sum_q      <= '0;
						res_ok_q   <= 1'b0;
						res_off_q  <= '0;
						res_size_q <= '0;
						ptr_q      <= '0;
						case (s_tuser)
							CMD_ADD: begin
								if (full) begin
									state_q <= S_OUT;
								end else if (count_q == '0) begin
									state_q <= S_WRADD;
								end else begin
									state_q <= S_SRD;
								end
							end
							CMD_REM: begin
								state_q <= (count_q == '0) ? S_OUT : S_SRD;
							end
							default: begin
								ptr_q   <= CW'(s_tdata[207:192]);
								state_q <= idx_ok ? S_IRD : S_OUT;
							end
						endcase
					end
				end
				S_SRD: begin
					state_q <= S_SCMP;
				end
				S_SCMP: begin
					if (rd_q.name == key_q) begin
						if (cmd_q == CMD_ADD) begin
							state_q <= S_OUT;
						end else if (ptr_inc == count_q) begin
							count_q  <= cnt_dec;
							res_ok_q <= 1'b1;
							state_q  <= S_OUT;
						end else begin
							ptr_q   <= ptr_inc;
							state_q <= S_MRD;
						end
					end else if (ptr_inc == count_q) begin
						if (cmd_q == CMD_ADD) begin
							ptr_q   <= cnt_dec;
							state_q <= S_LRD;
						end else begin
							state_q <= S_OUT;
						end
					end else begin
						ptr_q   <= ptr_inc;
						state_q <= S_SRD;
					end
				end
				S_MRD: begin
					state_q <= S_MWR;
				end
				S_MWR: begin
					// move entry down one slot, then advance
					if (ptr_inc == count_q) begin
						count_q  <= cnt_dec;
						res_ok_q <= 1'b1;
						state_q  <= S_OUT;
					end else begin
						ptr_q   <= ptr_inc;
						state_q <= S_MRD;
					end
				end
				S_LRD: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					sum_q   <= rd_q.offset + 32'(rd_q.ssize);
					state_q <= S_RCP;
				end
				S_RCP: begin
					// quotient by the alignment via reciprocal multiply, exact for 32 bits
					prod_q  <= 65'(sum_q) * 65'(RCP_MUL);
					state_q <= S_QSUB;
				end
				S_QSUB: begin
					rem_q   <= sum_q - quot * ALIGN_32;
					state_q <= S_RND;
				end
				S_RND: begin
					if (rem_q != '0) begin
						sum_q <= sum_q + (ALIGN_32 - rem_q);
					end
					state_q <= S_WRADD;
				end
				S_WRADD: begin
					count_q   <= count_q + CW'(1);
					res_ok_q  <= 1'b1;
					res_off_q <= sum_q;
					state_q   <= S_OUT;
				end
				S_IRD: begin
					state_q <= S_ICHK;
				end
				S_ICHK: begin
					if (cmd_q == CMD_GET) begin
						res_ok_q   <= 1'b1;
						res_size_q <= rd_q.ssize;
					end else begin
						res_ok_q <= (rd_q.ssize != ssz_q);
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					// hold until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_ok_q     <= res_ok_q;
						m_off_q    <= res_off_q;
						m_size_q   <= res_size_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_add_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRADD) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("add did not advance entry count");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RND) |-> ({16'h0000, rem_q} < 48'(ALIGN_UNITS)))
		else $error("remainder not below alignment");

	a_off_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[31:0] != 32'h0)) |-> m_tuser[0])
		else $error("offset given without success");

endmodule

`default_nettype wire
